### rtl/core/stl_pkg.sv
// types, constants and helper functions shared by the source text lexer
package stl_pkg;

	localparam int OFFSET_BITS    = 24;
	localparam int POSITION_BITS  = 16;
	localparam int LENGTH_LIMIT   = 255;
	localparam int VALUE_LEN_BITS = 8;
	localparam int LEN_CNT_BITS   = $clog2(LENGTH_LIMIT + 2);
	localparam int QUEUE_DEPTH    = 4;
	localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

	typedef logic [POSITION_BITS-1:0] pos_t;
	typedef logic [OFFSET_BITS-1:0]   off_t;
	typedef logic [LEN_CNT_BITS-1:0]  len_cnt_t;
	typedef logic [4:0]               kind_t;

	// scan modes
	localparam logic [2:0] MODE_IDLE     = 3'd0;
	localparam logic [2:0] MODE_IDENT    = 3'd1;
	localparam logic [2:0] MODE_NUMBER   = 3'd2;
	localparam logic [2:0] MODE_STRING   = 3'd3;
	localparam logic [2:0] MODE_OPERATOR = 3'd4;
	localparam logic [2:0] MODE_COMMENT  = 3'd5;

	// token kinds
	localparam kind_t K_EOF       = 5'd0;
	localparam kind_t K_NUMBER    = 5'd1;
	localparam kind_t K_IDENT     = 5'd2;
	localparam kind_t K_VAR       = 5'd3;
	localparam kind_t K_STRING    = 5'd11;
	localparam kind_t K_EQEQ      = 5'd12;
	localparam kind_t K_NOTEQ     = 5'd13;
	localparam kind_t K_LTE       = 5'd14;
	localparam kind_t K_GTE       = 5'd15;
	localparam kind_t K_AND       = 5'd16;
	localparam kind_t K_OR        = 5'd17;
	localparam kind_t K_EQUALS    = 5'd18;
	localparam kind_t K_BANG      = 5'd19;
	localparam kind_t K_SEMICOLON = 5'd20;
	localparam kind_t K_LPAREN    = 5'd21;
	localparam kind_t K_RPAREN    = 5'd22;
	localparam kind_t K_LBRACE    = 5'd23;
	localparam kind_t K_RBRACE    = 5'd24;
	localparam kind_t K_LBRACKET  = 5'd25;
	localparam kind_t K_RBRACKET  = 5'd26;
	localparam kind_t K_UNKNOWN   = 5'd27;

	// characters with a role of their own
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_SLASH     = 8'h2F;

	// keyword spellings, zero padded
	localparam logic [7:0] KW_TEXT [8][5] = '{
		'{"v", "a", "r", 8'h00, 8'h00},
		'{"c", "o", "n", "s", "t"},
		'{"i", "f", 8'h00, 8'h00, 8'h00},
		'{"t", "r", "u", "e", 8'h00},
		'{"f", "a", "l", "s", "e"},
		'{"p", "r", "i", "n", "t"},
		'{"p", "u", "s", "h", 8'h00},
		'{"p", "o", "p", 8'h00, 8'h00}
	};
	localparam logic [2:0] KW_LEN [8] = '{3'd3, 3'd5, 3'd2, 3'd4, 3'd5, 3'd5, 3'd4, 3'd3};

	typedef struct packed {
		logic       kind;
		logic [7:0] char_byte;
	} in_beat_t;

	typedef struct packed {
		kind_t                     token_kind;
		pos_t                      token_line;
		pos_t                      token_column;
		off_t                      value_offset;
		logic [VALUE_LEN_BITS-1:0] value_length;
		logic                      length_clipped;
		logic                      last;
	} token_t;

	// up to two tokens produced by one beat
	typedef struct packed {
		logic [1:0] count;
		token_t     first;
		token_t     second;
	} push_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == " ") || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_ident_start(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == "_");
	endfunction

	function automatic logic is_ident_char(input logic [7:0] c);
		return is_ident_start(c) || is_digit(c);
	endfunction

	function automatic logic is_op_start(input logic [7:0] c);
		return (c == "=") || (c == "!") || (c == "<") || (c == ">") ||
			(c == "&") || (c == "|") || (c == CH_SLASH);
	endfunction

	function automatic pos_t pos_inc(input pos_t v);
		return (&v) ? v : v + pos_t'(1);
	endfunction

	function automatic off_t off_inc(input off_t v);
		return (&v) ? v : v + off_t'(1);
	endfunction

	function automatic len_cnt_t len_inc(input len_cnt_t v);
		return (v <= len_cnt_t'(LENGTH_LIMIT)) ? v + len_cnt_t'(1) : v;
	endfunction

	// drop keyword candidates whose spelling differs at this position
	function automatic logic [7:0] kw_filter(input logic [7:0] cand, input len_cnt_t idx,
			input logic [7:0] c);
		logic [7:0] res;
		res = cand;
		for (int k = 0; k < 8; k++) begin
			if (idx >= len_cnt_t'(KW_LEN[k]))
				res[k] = 1'b0;
			else if (KW_TEXT[k][idx[2:0]] != c)
				res[k] = 1'b0;
		end
		return res;
	endfunction

	function automatic kind_t ident_kind(input logic [7:0] cand, input len_cnt_t len);
		kind_t res;
		res = K_IDENT;
		for (int k = 0; k < 8; k++) begin
			if (cand[k] && len == len_cnt_t'(KW_LEN[k]))
				res = kind_t'(K_VAR + k);
		end
		return res;
	endfunction

	function automatic kind_t single_kind(input logic [7:0] c);
		kind_t res;
		case (c)
			";":     res = K_SEMICOLON;
			"(":     res = K_LPAREN;
			")":     res = K_RPAREN;
			"{":     res = K_LBRACE;
			"}":     res = K_RBRACE;
			"[":     res = K_LBRACKET;
			"]":     res = K_RBRACKET;
			default: res = K_UNKNOWN;
		endcase
		return res;
	endfunction

	// two-character operator, K_EOF when the pair is not one
	function automatic kind_t pair_kind(input logic [7:0] p, input logic [7:0] c);
		kind_t res;
		res = K_EOF;
		if (c == "=") begin
			if (p == "=")
				res = K_EQEQ;
			else if (p == "!")
				res = K_NOTEQ;
			else if (p == "<")
				res = K_LTE;
			else if (p == ">")
				res = K_GTE;
		end
		if (p == "&" && c == "&")
			res = K_AND;
		if (p == "|" && c == "|")
			res = K_OR;
		return res;
	endfunction

	function automatic token_t pack_token(input kind_t kind, input pos_t line, input pos_t col,
			input off_t off, input len_cnt_t len);
		token_t t;
		t.token_kind     = kind;
		t.token_line     = line;
		t.token_column   = col;
		t.value_offset   = off;
		t.length_clipped = len > len_cnt_t'(LENGTH_LIMIT);
		t.value_length   = t.length_clipped ? VALUE_LEN_BITS'(LENGTH_LIMIT)
			: len[VALUE_LEN_BITS-1:0];
		t.last           = 1'b0;
		return t;
	endfunction

endpackage

### rtl/core/stl_stream_if.sv
// valid/ready stream channel
interface stl_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/core/source_text_lexer_unit.sv
// top level of the streaming source text lexer
//
//   channel   dir   payload                                   accepted when
//   text      in    kind, char_byte                           text.valid && text.ready
//   tokens    out   token_kind .. length_clipped, last        tokens.valid && tokens.ready
//
// one byte per cycle sustained while the queue has room; every beat is registered, scanned and its
// zero, one or two tokens written to a four-entry queue, so a token passes the input register
// and the queue before it appears on the output.
// text.ready drops only while the queue has fewer than two free entries.
// arst_n clears the scanner to line 1, column 1, offset 0; an end beat does the same.
module source_text_lexer_unit (
	input  logic         clk,
	input  logic         arst_n,
	stl_stream_if.sink   text,
	stl_stream_if.source tokens
);
	import stl_pkg::*;

	push_t push;
	logic  room;

	stl_scanner u_scanner (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.room   (room),
		.push   (push)
	);

	stl_token_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.tokens (tokens)
	);

endmodule

### rtl/core/stl_scanner.sv
// input register and scanner state with next-token logic
module stl_scanner (
	input  logic          clk,
	input  logic          arst_n,
	stl_stream_if.sink    text,
	input  logic          room,
	output stl_pkg::push_t push
);
	import stl_pkg::*;

	logic       valid_s1;
	in_beat_t   beat_s1;
	logic       advance;

	logic [2:0] mode_q, mode_n;
	logic [7:0] pend_q, pend_n;
	logic [7:0] kwc_q, kwc_n;
	logic       bs_q, bs_n;
	pos_t       line_q, line_n;
	pos_t       col_q, col_n;
	off_t       off_q, off_n;
	pos_t       scol_q, scol_n;
	off_t       soff_q, soff_n;
	len_cnt_t   tlen_q, tlen_n;

	token_t     tok0, tok1;
	logic [1:0] n_tok;

	assign advance    = valid_s1 && room;
	assign text.ready = !valid_s1 || room;

	always_comb begin
		logic [7:0] c;
		logic       fresh;
		logic       pending;
		kind_t      fkind;
		len_cnt_t   flen;
		token_t     ftok;
		token_t     single;
		kind_t      pk;

		c     = beat_s1.char_byte;
		fresh = 1'b0;
		pk    = pair_kind(pend_q, c);

		mode_n = mode_q;
		pend_n = pend_q;
		kwc_n  = kwc_q;
		bs_n   = bs_q;
		line_n = line_q;
		col_n  = col_q;
		off_n  = off_q;
		scol_n = scol_q;
		soff_n = soff_q;
		tlen_n = tlen_q;
		tok0   = '0;
		tok1   = '0;
		n_tok  = 2'd0;

		// token being collected, as it would be emitted now
		pending = 1'b1;
		flen    = tlen_q;
		unique case (mode_q)
			MODE_IDENT:  fkind = ident_kind(kwc_q, tlen_q);
			MODE_NUMBER: fkind = K_NUMBER;
			MODE_STRING: fkind = K_STRING;
			MODE_OPERATOR: begin
				fkind = (pend_q == "=") ? K_EQUALS : (pend_q == "!") ? K_BANG : K_UNKNOWN;
				flen  = len_cnt_t'(1);
			end
			default: begin
				fkind   = K_UNKNOWN;
				pending = 1'b0;
			end
		endcase
		ftok   = pack_token(fkind, line_q, scol_q, soff_q, flen);
		single = pack_token(single_kind(c), line_q, col_q, off_q, len_cnt_t'(1));

		if (beat_s1.kind) begin
			// end of text: flush, then eof, then back to reset values
			if (pending) begin
				tok0  = ftok;
				tok1  = pack_token(K_EOF, line_q, col_q, off_q, '0);
				n_tok = 2'd2;
			end else begin
				tok0  = pack_token(K_EOF, line_q, col_q, off_q, '0);
				n_tok = 2'd1;
			end
			mode_n = MODE_IDLE;
			pend_n = '0;
			kwc_n  = '1;
			bs_n   = 1'b0;
			line_n = pos_t'(1);
			col_n  = pos_t'(1);
			off_n  = '0;
			scol_n = pos_t'(1);
			soff_n = '0;
			tlen_n = '0;
		end else begin
			unique case (mode_q)
				MODE_IDENT: begin
					if (is_ident_char(c)) begin
						kwc_n  = kw_filter(kwc_q, tlen_q, c);
						tlen_n = len_inc(tlen_q);
					end else begin
						tok0  = ftok;
						n_tok = 2'd1;
						fresh = 1'b1;
					end
				end
				MODE_NUMBER: begin
					if (is_digit(c)) begin
						tlen_n = len_inc(tlen_q);
					end else begin
						tok0  = ftok;
						n_tok = 2'd1;
						fresh = 1'b1;
					end
				end
				MODE_STRING: begin
					if (c == CH_QUOTE && !bs_q) begin
						tok0   = ftok;
						n_tok  = 2'd1;
						bs_n   = 1'b0;
						mode_n = MODE_IDLE;
					end else begin
						tlen_n = len_inc(tlen_q);
						bs_n   = (c == CH_BACKSLASH);
					end
				end
				MODE_OPERATOR: begin
					if (pend_q == CH_SLASH && c == CH_SLASH) begin
						mode_n = MODE_COMMENT;
						pend_n = '0;
					end else if (pk != K_EOF) begin
						tok0   = pack_token(pk, line_q, scol_q, soff_q, len_cnt_t'(2));
						n_tok  = 2'd1;
						mode_n = MODE_IDLE;
						pend_n = '0;
					end else begin
						tok0   = ftok;
						n_tok  = 2'd1;
						pend_n = '0;
						fresh  = 1'b1;
					end
				end
				MODE_COMMENT: begin
					if (c == CH_NEWLINE)
						mode_n = MODE_IDLE;
				end
				default: begin
					fresh = 1'b1;
				end
			endcase

			if (fresh) begin
				mode_n = MODE_IDLE;
				if (is_space(c)) begin
					mode_n = MODE_IDLE;
				end else if (c == CH_QUOTE) begin
					scol_n = col_q;
					soff_n = off_inc(off_q);
					tlen_n = '0;
					bs_n   = 1'b0;
					mode_n = MODE_STRING;
				end else if (is_ident_start(c)) begin
					scol_n = col_q;
					soff_n = off_q;
					kwc_n  = kw_filter(8'hFF, '0, c);
					tlen_n = len_cnt_t'(1);
					mode_n = MODE_IDENT;
				end else if (is_digit(c)) begin
					scol_n = col_q;
					soff_n = off_q;
					tlen_n = len_cnt_t'(1);
					mode_n = MODE_NUMBER;
				end else if (is_op_start(c)) begin
					scol_n = col_q;
					soff_n = off_q;
					tlen_n = len_cnt_t'(1);
					pend_n = c;
					mode_n = MODE_OPERATOR;
				end else if (n_tok == 2'd0) begin
					tok0  = single;
					n_tok = 2'd1;
				end else begin
					tok1  = single;
					n_tok = 2'd2;
				end
			end

			// every byte moves the position counters
			off_n = off_inc(off_q);
			if (c == CH_NEWLINE) begin
				line_n = pos_inc(line_q);
				col_n  = pos_t'(1);
			end else begin
				col_n  = pos_inc(col_q);
			end
		end

		if (n_tok == 2'd1)
			tok0.last = 1'b1;
		if (n_tok == 2'd2)
			tok1.last = 1'b1;
	end

	assign push.count  = advance ? n_tok : 2'd0;
	assign push.first  = tok0;
	assign push.second = tok1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready)
			beat_s1 <= text.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pend_q <= '0;
			kwc_q  <= '1;
			bs_q   <= 1'b0;
			line_q <= pos_t'(1);
			col_q  <= pos_t'(1);
			off_q  <= '0;
			scol_q <= pos_t'(1);
			soff_q <= '0;
			tlen_q <= '0;
		end else if (advance) begin
			mode_q <= mode_n;
			pend_q <= pend_n;
			kwc_q  <= kwc_n;
			bs_q   <= bs_n;
			line_q <= line_n;
			col_q  <= col_n;
			off_q  <= off_n;
			scol_q <= scol_n;
			soff_q <= soff_n;
			tlen_q <= tlen_n;
		end
	end

	// end beat leaves the scanner at the start of a fresh text
	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && beat_s1.kind |=> mode_q == MODE_IDLE && line_q == pos_t'(1) &&
			col_q == pos_t'(1) && off_q == '0)
		else $error("scanner not restarted after end beat");

	a_one_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd1 |-> push.first.last)
		else $error("single token without last");

	a_two_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> push.second.last && !push.first.last)
		else $error("token pair with wrong last marking");

	a_two_only: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> beat_s1.kind || push.first.token_kind != K_EOF)
		else $error("eof token ahead of another token");

endmodule

### rtl/core/stl_token_queue.sv
// small token queue between the scanner and the output channel
module stl_token_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  stl_pkg::push_t push,
	output logic           room,
	stl_stream_if.source   tokens
);
	import stl_pkg::*;

	typedef logic [QPTR_BITS-1:0] qptr_t;
	typedef logic [QCNT_BITS-1:0] qcnt_t;

	token_t entry_q [QUEUE_DEPTH];
	qptr_t  wr_q;
	qptr_t  rd_q;
	qcnt_t  count_q;
	logic   pop;

	// two free slots so a beat that yields two tokens always fits
	assign room          = count_q <= qcnt_t'(QUEUE_DEPTH - 2);
	assign tokens.valid  = count_q != '0;
	assign tokens.data   = entry_q[rd_q];
	assign pop           = tokens.valid && tokens.ready;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			entry_q[wr_q] <= push.first;
		if (push.count == 2'd2)
			entry_q[qptr_t'(wr_q + qptr_t'(1))] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= qptr_t'(wr_q + qptr_t'(push.count));
			rd_q    <= qptr_t'(rd_q + qptr_t'(pop));
			count_q <= qcnt_t'(count_q + qcnt_t'(push.count) - qcnt_t'(pop));
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= qcnt_t'(QUEUE_DEPTH))
		else $error("token queue overflow");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> room)
		else $error("tokens pushed without room");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd3)
		else $error("illegal push count");

endmodule

### tb/sv/lexer_board_pkg.sv
// token scoreboard for the source text lexer: scanner image and result check
`timescale 1ns / 100ps
package lexer_board_pkg;
	import stl_pkg::*;

	class lexer_token_board;
		token_t      exp_tokens[$];
		int          errors;
		int          checked;
		string       kw_names[8];

		// image of the scanner
		logic [2:0]  mode;
		logic [7:0]  op_char;
		bit          bs_seen;
		pos_t        line_no;
		pos_t        col_no;
		pos_t        tok_col;
		off_t        pos_off;
		off_t        tok_off;
		int unsigned tok_len;
		logic [7:0]  word_buf[6];

		function new();
			kw_names = '{"var", "const", "if", "true", "false", "print", "push", "pop"};
			errors = 0;
			checked = 0;
			restart();
		endfunction

		function void restart();
			mode = MODE_IDLE;
			op_char = '0;
			bs_seen = 1'b0;
			line_no = pos_t'(1);
			col_no = pos_t'(1);
			tok_col = pos_t'(1);
			pos_off = '0;
			tok_off = '0;
			tok_len = 0;
		endfunction

		task report(string msg);
			errors++;
			$display("%s", msg);
		endtask

		function bit blank(logic [7:0] c);
			return c == " " || (c >= 8'h09 && c <= 8'h0D);
		endfunction

		function bit decimal(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function bit letter(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
		endfunction

		function bit op_lead(logic [7:0] c);
			return c inside {"=", "!", "<", ">", "&", "|", CH_SLASH};
		endfunction

		function off_t off_next(off_t v);
			return (&v) ? v : v + off_t'(1);
		endfunction

		function pos_t pos_next(pos_t v);
			return (&v) ? v : v + pos_t'(1);
		endfunction

		function void advance(logic [7:0] c);
			pos_off = off_next(pos_off);
			if (c == CH_NEWLINE) begin
				line_no = pos_next(line_no);
				col_no = pos_t'(1);
			end else begin
				col_no = pos_next(col_no);
			end
		endfunction

		function void grow();
			if (tok_len <= LENGTH_LIMIT)
				tok_len++;
		endfunction

		function void open_token();
			tok_col = col_no;
			tok_off = pos_off;
			tok_len = 0;
		endfunction

		function void push_token(kind_t k, pos_t col, off_t off, int unsigned len);
			token_t t;
			t.token_kind = k;
			t.token_line = line_no;
			t.token_column = col;
			t.value_offset = off;
			t.length_clipped = len > LENGTH_LIMIT;
			t.value_length = t.length_clipped ? VALUE_LEN_BITS'(LENGTH_LIMIT)
				: VALUE_LEN_BITS'(len);
			t.last = 1'b0;
			exp_tokens.push_back(t);
		endfunction

		function kind_t word_kind();
			kind_t k_out;
			bit same;
			k_out = K_IDENT;
			for (int k = 0; k < 8; k++) begin
				same = tok_len == kw_names[k].len();
				for (int i = 0; i < kw_names[k].len() && same; i++)
					if (word_buf[i] != kw_names[k][i])
						same = 1'b0;
				if (same)
					k_out = kind_t'(K_VAR + k);
			end
			return k_out;
		endfunction

		function kind_t lone_kind(logic [7:0] c);
			case (c)
				";": return K_SEMICOLON;
				"(": return K_LPAREN;
				")": return K_RPAREN;
				"{": return K_LBRACE;
				"}": return K_RBRACE;
				"[": return K_LBRACKET;
				"]": return K_RBRACKET;
				default: return K_UNKNOWN;
			endcase
		endfunction

		// K_EOF when the two bytes make no operator
		function kind_t pair_of(logic [7:0] p, logic [7:0] c);
			if (c == "=") begin
				case (p)
					"=": return K_EQEQ;
					"!": return K_NOTEQ;
					"<": return K_LTE;
					">": return K_GTE;
					default: ;
				endcase
			end
			if (p == "&" && c == "&")
				return K_AND;
			if (p == "|" && c == "|")
				return K_OR;
			return K_EOF;
		endfunction

		function void flush_pending();
			case (mode)
				MODE_IDENT: push_token(word_kind(), tok_col, tok_off, tok_len);
				MODE_NUMBER: push_token(K_NUMBER, tok_col, tok_off, tok_len);
				MODE_STRING: push_token(K_STRING, tok_col, tok_off, tok_len);
				MODE_OPERATOR: push_token(op_char == "=" ? K_EQUALS :
					op_char == "!" ? K_BANG : K_UNKNOWN, tok_col, tok_off, 1);
				default: ;
			endcase
			mode = MODE_IDLE;
			op_char = '0;
		endfunction

		function void note_beat(in_beat_t b);
			logic [7:0] c;
			int unsigned first;
			bit fresh;
			kind_t pk;
			token_t t;
			c = b.char_byte;
			first = exp_tokens.size();
			fresh = 1'b1;
			if (b.kind) begin
				flush_pending();
				push_token(K_EOF, col_no, pos_off, 0);
				restart();
				fresh = 1'b0;
			end else begin
				case (mode)
					MODE_IDENT: begin
						if (letter(c) || decimal(c)) begin
							if (tok_len < 6)
								word_buf[tok_len] = c;
							grow();
							advance(c);
							fresh = 1'b0;
						end else begin
							flush_pending();
						end
					end
					MODE_NUMBER: begin
						if (decimal(c)) begin
							grow();
							advance(c);
							fresh = 1'b0;
						end else begin
							flush_pending();
						end
					end
					MODE_STRING: begin
						fresh = 1'b0;
						if (c == CH_QUOTE && !bs_seen) begin
							flush_pending();
							bs_seen = 1'b0;
						end else begin
							grow();
							bs_seen = c == CH_BACKSLASH;
						end
						advance(c);
					end
					MODE_OPERATOR: begin
						pk = pair_of(op_char, c);
						if (op_char == CH_SLASH && c == CH_SLASH) begin
							mode = MODE_COMMENT;
							op_char = '0;
							advance(c);
							fresh = 1'b0;
						end else if (pk != K_EOF) begin
							push_token(pk, tok_col, tok_off, 2);
							mode = MODE_IDLE;
							op_char = '0;
							advance(c);
							fresh = 1'b0;
						end else begin
							flush_pending();
						end
					end
					MODE_COMMENT: begin
						if (c == CH_NEWLINE)
							mode = MODE_IDLE;
						advance(c);
						fresh = 1'b0;
					end
					default: mode = MODE_IDLE;
				endcase
			end
			if (fresh) begin
				if (blank(c)) begin
				end else if (c == CH_QUOTE) begin
					open_token();
					tok_off = off_next(pos_off);
					bs_seen = 1'b0;
					mode = MODE_STRING;
				end else if (letter(c)) begin
					open_token();
					word_buf[0] = c;
					grow();
					mode = MODE_IDENT;
				end else if (decimal(c)) begin
					open_token();
					tok_len = 1;
					mode = MODE_NUMBER;
				end else if (op_lead(c)) begin
					open_token();
					tok_len = 1;
					op_char = c;
					mode = MODE_OPERATOR;
				end else begin
					push_token(lone_kind(c), col_no, pos_off, 1);
				end
				advance(c);
			end
			if (exp_tokens.size() > first) begin
				t = exp_tokens.pop_back();
				t.last = 1'b1;
				exp_tokens.push_back(t);
			end
		endfunction

		task check_token(token_t got);
			token_t want;
			if (exp_tokens.size() == 0) begin
				report($sformatf("token kind %0d at line %0d col %0d with nothing expected",
					got.token_kind, got.token_line, got.token_column));
				return;
			end
			want = exp_tokens.pop_front();
			if (got.token_kind !== want.token_kind)
				report($sformatf("token %0d kind: got %0d expected %0d",
					checked, got.token_kind, want.token_kind));
			if (got.token_line !== want.token_line)
				report($sformatf("token %0d line: got %0d expected %0d",
					checked, got.token_line, want.token_line));
			if (got.token_column !== want.token_column)
				report($sformatf("token %0d column: got %0d expected %0d",
					checked, got.token_column, want.token_column));
			if (got.value_offset !== want.value_offset)
				report($sformatf("token %0d offset: got %0d expected %0d",
					checked, got.value_offset, want.value_offset));
			if (got.value_length !== want.value_length)
				report($sformatf("token %0d length: got %0d expected %0d",
					checked, got.value_length, want.value_length));
			if (got.length_clipped !== want.length_clipped)
				report($sformatf("token %0d clipped: got %0d expected %0d",
					checked, got.length_clipped, want.length_clipped));
			if (got.last !== want.last)
				report($sformatf("token %0d last: got %0d expected %0d",
					checked, got.last, want.last));
			checked++;
		endtask
	endclass

endpackage

### tb/sv/tb_top.sv
// top of the lexer testbench: clock, reset, text driver, token sink and final check
`timescale 1ns / 100ps
module tb_top;
	import stl_pkg::*;
	import lexer_board_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int TEXT_BEATS  = 1850;

	logic clk = 1'b0;
	logic arst_n;

	stl_stream_if #(.T(in_beat_t)) text();
	stl_stream_if #(.T(token_t)) tokens();

	source_text_lexer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.tokens (tokens)
	);

	lexer_token_board board;

	logic [7:0] src[$];
	string      kw_words[8] = '{"var", "const", "if", "true", "false", "print", "push", "pop"};
	string      pair_ops[6] = '{"==", "!=", "<=", ">=", "&&", "||"};
	string      lone_ops = "=!<>&|/;(){}[]";

	int         burst_left = 0;
	int         beats_sent = 0;
	int         quiet_cycles = 0;
	bit         hold_req = 1'b0;
	int         hold_left = 0;
	logic [7:0] rx_pattern = 8'hFF;
	int         rx_step = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// token sink: stalls on a rotating pattern, or holds off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			tokens.ready <= 1'b0;
		end else begin
			if (rx_step == 0) begin
				case ($urandom_range(0, 3))
					0: rx_pattern = 8'hFF;
					1: rx_pattern = 8'h11;
					default: rx_pattern = 8'($urandom);
				endcase
				rx_step = $urandom_range(16, 120);
			end
			rx_step--;
			tokens.ready <= rx_pattern[rx_step % 8];
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (tokens.valid && tokens.ready)
				board.check_token(tokens.data);
			if (text.valid && text.ready)
				board.note_beat(text.data);
			if ((tokens.valid && tokens.ready) || (text.valid && text.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin
		do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// text driver: bursts of beats with random gaps in between
	task send_beat(input logic is_end, input logic [7:0] ch);
		in_beat_t beat;
		beat.kind = is_end;
		beat.char_byte = ch;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				text.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		text.valid <= 1'b1;
		text.data <= beat;
		@(posedge clk);
		while (!text.ready)
			@(posedge clk);
		burst_left--;
		beats_sent++;
		@(negedge clk);
	endtask

	task send_text();
		foreach (src[i])
			send_beat(1'b0, src[i]);
		send_beat(1'b1, 8'($urandom));
		src.delete();
	endtask

	function automatic void put(string s);
		for (int i = 0; i < s.len(); i++)
			src.push_back(s[i]);
	endfunction

	function automatic logic [7:0] word_char(bit lead);
		int r;
		r = $urandom_range(0, lead ? 52 : 62);
		if (r < 26)
			return 8'("a" + r);
		else if (r < 52)
			return 8'("A" + r - 26);
		else if (r == 52)
			return "_";
		return 8'("0" + r - 53);
	endfunction

	function automatic logic [7:0] blank_char();
		case ($urandom_range(0, 5))
			0: return " ";
			1: return "\t";
			2: return CH_NEWLINE;
			3: return 8'h0B;
			4: return 8'h0C;
			default: return 8'h0D;
		endcase
	endfunction

	// value whose length lies around the clipping point of the length field
	function automatic void add_long();
		int n;
		n = $urandom_range(250, 300);
		case ($urandom_range(0, 2))
			0: begin
				src.push_back(CH_QUOTE);
				repeat (n) src.push_back(word_char(1'b0));
				src.push_back(CH_QUOTE);
			end
			1: begin
				src.push_back(word_char(1'b1));
				repeat (n - 1) src.push_back(word_char(1'b0));
			end
			default: repeat (n) src.push_back(8'("0" + $urandom_range(0, 9)));
		endcase
		src.push_back(blank_char());
	endfunction

	function automatic void add_piece();
		int r;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			put(kw_words[$urandom_range(0, 7)]);
			case ($urandom_range(0, 6))
				0: src.push_back(word_char(1'b0));
				1: void'(src.pop_back());
				default: ;
			endcase
		end else if (r < 27) begin
			src.push_back(word_char(1'b1));
			repeat ($urandom_range(0, 7)) src.push_back(word_char(1'b0));
		end else if (r < 39) begin
			repeat ($urandom_range(1, 6)) src.push_back(8'("0" + $urandom_range(0, 9)));
		end else if (r < 49) begin
			src.push_back(CH_QUOTE);
			repeat ($urandom_range(0, 10)) begin
				case ($urandom_range(0, 9))
					5: src.push_back(CH_BACKSLASH);
					6: put("\\\"");
					7: put("\\\\\"");
					8: src.push_back(blank_char());
					9: src.push_back(8'($urandom));
					default: src.push_back(word_char(1'b0));
				endcase
			end
			// sometimes left open so the rest of the text ends up inside it
			if ($urandom_range(0, 9) != 0)
				src.push_back(CH_QUOTE);
		end else if (r < 59) begin
			put(pair_ops[$urandom_range(0, 5)]);
		end else if (r < 74) begin
			src.push_back(lone_ops[$urandom_range(0, lone_ops.len() - 1)]);
		end else if (r < 79) begin
			put("//");
			repeat ($urandom_range(0, 8)) begin
				b = 8'($urandom);
				if (b == CH_NEWLINE)
					b = " ";
				src.push_back(b);
			end
			if ($urandom_range(0, 4) != 0)
				src.push_back(CH_NEWLINE);
		end else if (r < 87) begin
			repeat ($urandom_range(1, 3)) src.push_back(blank_char());
		end else begin
			src.push_back(8'($urandom));
		end
		if ($urandom_range(0, 1) == 0)
			src.push_back(blank_char());
	endfunction

	initial begin
		int text_no;
		int pieces;
		text.valid = 1'b0;
		text.data = '0;
		tokens.ready = 1'b0;
		arst_n = 1'b0;
		board = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// keyword, parens, string with an escaped quote, comment
		put("print(\"a\\\"b\")//z\n");
		send_text();
		// lone partners, zero byte and a byte above 127
		put("&|");
		src.push_back(8'h00);
		src.push_back(8'hFF);
		send_text();
		// string still open at the end
		put("\"ab");
		send_text();

		text_no = 0;
		while (beats_sent < TEXT_BEATS) begin
			if (text_no == 2 || text_no == 17) begin
				hold_req = 1'b1;
				pieces = 40;
			end else begin
				pieces = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
			end
			if ($urandom_range(0, 24) == 0)
				add_long();
			repeat (pieces) add_piece();
			send_text();
			text_no++;
		end
		text.valid <= 1'b0;

		while (board.exp_tokens.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (board.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
